// ----- hdl/lpm_pkg.sv -----
package lpm_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int MAX_PARTS_DEF = 16;

  localparam int VALUE_W = 16;
  localparam int PARTS_W = 5;
  localparam int INDEX_W = 7;
  localparam int PSUM_W  = 22;

  localparam logic [PARTS_W-1:0] NUM_PARTS_RST = PARTS_W'(3);

  typedef struct packed {
    logic [VALUE_W-1:0] element_value;
    logic               last_item;
  } lpm_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] part_start;
    logic [INDEX_W-1:0] part_end;
    logic [PSUM_W-1:0]  part_sum;
    logic               part_empty;
    logic               last_part;
  } lpm_out_t;

endpackage

// ----- hdl/linear_partition_min_max_top.sv -----
// Loading: one element item is taken per cycle while the block is idle.
// After the last item the block stalls its input while it fills the tables
// (skipped for fewer than two elements or parts), walks the cuts back and
// emits one part item per part.
// Reset (rst_ni low, asynchronous) empties the list and sets num_parts to 3.
module linear_partition_min_max_top
  import lpm_pkg::*;
#(
  parameter int MaxItems = MAX_ITEMS_DEF,
  parameter int MaxParts = MAX_PARTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PARTS_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpm_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpm_out_t           out_data_o
);

  // Index width holds 0..MaxItems, part width holds 0..MaxParts. A prefix sum of
  // MaxItems sixteen-bit elements fits in SumW bits.
  localparam int IW   = $clog2(MaxItems + 1);
  localparam int JW   = $clog2(MaxParts + 1);
  localparam int SumW = VALUE_W + IW;
  localparam int TabD = 2 ** (IW + JW);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DP_SETUP = 4'd1;
  localparam logic [3:0] S_DP_PSI   = 4'd2;
  localparam logic [3:0] S_DP_RD    = 4'd3;
  localparam logic [3:0] S_DP_CMP   = 4'd4;
  localparam logic [3:0] S_DP_WR    = 4'd5;
  localparam logic [3:0] S_BT_INIT  = 4'd6;
  localparam logic [3:0] S_BT_STEP  = 4'd7;
  localparam logic [3:0] S_BT_CUT   = 4'd8;
  localparam logic [3:0] S_EMIT_RD  = 4'd9;
  localparam logic [3:0] S_EMIT_LD  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [PARTS_W-1:0] num_parts_q;
  logic [IW-1:0]      count_q, count_d;
  logic [SumW-1:0]    acc_q, acc_d;
  logic               out_valid_q;

  logic [IW-1:0]      n_q, i_q, x_q, e_q, prev_q, where_q;
  logic [JW-1:0]      k_q, j_q;
  logic [SumW-1:0]    psi_q, best_q, psprev_q;
  logic [IW-1:0]      ends_q [MaxParts + 1];
  lpm_out_t           out_q;

  logic in_acc;
  logic out_acc;
  logic room;
  logic [JW-1:0] k_clamp;

  logic                 ps_we;
  logic [IW-1:0]        ps_waddr;
  logic [SumW-1:0]      ps_wdata;
  logic [IW-1:0]        ps_raddr;
  logic [SumW-1:0]      ps_rdata;
  logic                 tab_we;
  logic [IW+JW-1:0]     tab_waddr;
  logic [IW+JW-1:0]     cost_raddr;
  logic [IW+JW-1:0]     cut_raddr;
  logic [SumW-1:0]      cost_rdata;
  logic [IW-1:0]        cut_rdata;

  logic [SumW-1:0] cmp_cost;
  logic            cmp_take;

  logic [IW:0]     part_s;
  logic            part_empty;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_acc     = out_valid_q && !out_stall_i;

  // Elements past capacity are dropped, but a last marker on one still counts.
  assign room    = (count_q != IW'(MaxItems));
  assign count_d = room ? IW'(count_q + 1'b1) : count_q;
  assign acc_d   = acc_q + SumW'(in_data_i.element_value);

  // A part count of zero acts as one; counts above the table size saturate.
  always_comb begin
    if (num_parts_q == '0) begin
      k_clamp = JW'(1);
    end else if (int'(num_parts_q) > MaxParts) begin
      k_clamp = JW'(MaxParts);
    end else begin
      k_clamp = JW'(num_parts_q);
    end
  end

  // Prefix sums live at entries 1..n; entry zero is never read because the
  // emit pass starts its running prefix at zero.
  assign ps_we    = in_acc && room;
  assign ps_waddr = count_d;
  assign ps_wdata = acc_d;

  always_comb begin
    case (state_q)
      S_DP_RD:   ps_raddr = x_q;
      S_EMIT_RD: ps_raddr = ends_q[j_q];
      default:   ps_raddr = i_q;
    endcase
  end

  // Table entries are addressed by element index in the upper bits and part
  // index in the lower bits. Only rows two and up of columns two and up are
  // ever written; the first row and the first column equal the prefix sums.
  assign tab_we     = (state_q == S_DP_WR);
  assign tab_waddr  = {i_q, j_q};
  assign cost_raddr = {x_q, JW'(j_q - 1'b1)};
  assign cut_raddr  = {e_q, j_q};

  lpm_ram #(.Width(SumW), .Depth(MaxItems + 1)) u_ps_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (ps_wdata),
    .raddr_i (ps_raddr),
    .rdata_o (ps_rdata)
  );

  lpm_ram #(.Width(SumW), .Depth(TabD)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (best_q),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rdata)
  );

  lpm_ram #(.Width(IW), .Depth(TabD)) u_cut_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (where_q),
    .raddr_i (cut_raddr),
    .rdata_o (cut_rdata)
  );

  // The one compare unit shared by every candidate cut of every table cell.
  lpm_cmp_unit #(.SumW(SumW)) u_cmp (
    .ps_x_i   (ps_rdata),
    .cost_x_i (cost_rdata),
    .use_ps_i ((x_q == IW'(1)) || (j_q == JW'(2))),
    .ps_i_i   (psi_q),
    .best_i   (best_q),
    .first_i  (x_q == IW'(1)),
    .cost_o   (cmp_cost),
    .take_o   (cmp_take)
  );

  // An empty part has its end equal to the end of the part before it.
  assign part_s     = {1'b0, prev_q} + 1'b1;
  assign part_empty = (ends_q[j_q] == prev_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.last_item) begin
          if ((count_d >= IW'(2)) && (k_clamp >= JW'(2))) begin
            state_d = S_DP_SETUP;
          end else begin
            state_d = S_BT_INIT;
          end
        end
      end
      S_DP_SETUP: state_d = S_DP_PSI;
      S_DP_PSI:   state_d = S_DP_RD;
      S_DP_RD:    state_d = S_DP_CMP;
      S_DP_CMP: begin
        state_d = (x_q == IW'(i_q - 1'b1)) ? S_DP_WR : S_DP_RD;
      end
      S_DP_WR: begin
        if (j_q == k_q) begin
          state_d = (i_q == n_q) ? S_BT_INIT : S_DP_SETUP;
        end else begin
          state_d = S_DP_RD;
        end
      end
      S_BT_INIT: state_d = S_BT_STEP;
      S_BT_STEP: begin
        if (j_q == JW'(1)) begin
          state_d = S_EMIT_RD;
        end else if (e_q > IW'(1)) begin
          state_d = S_BT_CUT;
        end
      end
      S_BT_CUT:  state_d = S_BT_STEP;
      S_EMIT_RD: begin
        if (!out_valid_q) begin
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: state_d = (j_q == k_q) ? S_IDLE : S_EMIT_RD;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_parts_q <= NUM_PARTS_RST;
      count_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_parts_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (in_data_i.last_item) begin
          count_q <= '0;
          acc_q   <= '0;
        end else if (room) begin
          count_q <= count_d;
          acc_q   <= acc_d;
        end
      end
      if (state_q == S_EMIT_LD) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer; the state register decides when they
  // are meaningful.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.last_item) begin
          n_q <= count_d;
          k_q <= k_clamp;
          i_q <= IW'(2);
          j_q <= JW'(2);
        end
      end
      S_DP_PSI: begin
        psi_q <= ps_rdata;
        x_q   <= IW'(1);
      end
      S_DP_CMP: begin
        if (cmp_take) begin
          best_q  <= cmp_cost;
          where_q <= x_q;
        end
        x_q <= IW'(x_q + 1'b1);
      end
      S_DP_WR: begin
        x_q <= IW'(1);
        if (j_q == k_q) begin
          j_q <= JW'(2);
          i_q <= IW'(i_q + 1'b1);
        end else begin
          j_q <= JW'(j_q + 1'b1);
        end
      end
      S_BT_INIT: begin
        e_q         <= n_q;
        j_q         <= k_q;
        ends_q[k_q] <= n_q;
      end
      S_BT_STEP: begin
        if (j_q == JW'(1)) begin
          prev_q   <= '0;
          psprev_q <= '0;
        end else if (e_q <= IW'(1)) begin
          ends_q[JW'(j_q - 1'b1)] <= e_q;
          j_q <= JW'(j_q - 1'b1);
        end
      end
      S_BT_CUT: begin
        ends_q[JW'(j_q - 1'b1)] <= cut_rdata;
        e_q <= cut_rdata;
        j_q <= JW'(j_q - 1'b1);
      end
      S_EMIT_LD: begin
        out_q.part_start <= INDEX_W'(part_s);
        out_q.part_end   <= INDEX_W'(ends_q[j_q]);
        out_q.part_sum   <= part_empty ? '0 : PSUM_W'(ps_rdata - psprev_q);
        out_q.part_empty <= part_empty;
        out_q.last_part  <= (j_q == k_q);
        prev_q           <= ends_q[j_q];
        psprev_q         <= ps_rdata;
        j_q              <= JW'(j_q + 1'b1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/lpm_ram.sv -----
module lpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lpm_cmp_unit.sv -----
module lpm_cmp_unit #(
  parameter int SumW = 23
) (
  input  logic [SumW-1:0] ps_x_i,
  input  logic [SumW-1:0] cost_x_i,
  input  logic            use_ps_i,
  input  logic [SumW-1:0] ps_i_i,
  input  logic [SumW-1:0] best_i,
  input  logic            first_i,
  output logic [SumW-1:0] cost_o,
  output logic            take_o
);

  logic [SumW-1:0] left;
  logic [SumW-1:0] right;

  // The cost of a cut is the larger of the best cost of the prefix and the sum of
  // the last run. Only a strictly smaller cost replaces the best, so the earliest
  // cut wins a tie.
  always_comb begin
    left   = use_ps_i ? ps_x_i : cost_x_i;
    right  = ps_i_i - ps_x_i;
    cost_o = (left > right) ? left : right;
    take_o = first_i || (cost_o < best_i);
  end

endmodule

// ----- sim/lpm_partition_checker.sv -----
module lpm_partition_checker
  import lpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               cfg_we_i,
  input  logic [PARTS_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  lpm_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  lpm_out_t           out_data_i,
  output int                 pending_o,
  output int                 fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NItems = MAX_ITEMS_DEF;
  localparam int NParts = MAX_PARTS_DEF;

  logic [PARTS_W-1:0] num_parts_q = NUM_PARTS_RST;
  int unsigned        run_sums [NItems+1];
  int unsigned        span_cost [NItems+1][NParts+1];
  int unsigned        span_cut  [NItems+1][NParts+1];
  int unsigned        elem_count = 0;
  lpm_out_t           parts_q [$];
  int                 fails = 0;

  assign pending_o = parts_q.size();
  assign fails_o   = fails;

  // Min-max partition of the loaded list, queued as the expected part items.
  function automatic void plan_parts(int unsigned n, int unsigned k_raw);
    int unsigned k, best, c, seg, e, s;
    int unsigned ends [NParts+1];
    int unsigned where;
    lpm_out_t    p;
    k = (k_raw < 1) ? 1 : (k_raw > NParts) ? NParts : k_raw;
    for (int i = 1; i <= n; i++) span_cost[i][1] = run_sums[i];
    for (int j = 1; j <= k; j++) begin
      span_cost[1][j] = run_sums[1];
      span_cut[1][j]  = 1;
    end
    for (int i = 2; i <= n; i++) begin
      for (int j = 2; j <= k; j++) begin
        best  = 32'hFFFF_FFFF;
        where = 1;
        for (int x = 1; x < i; x++) begin
          seg = run_sums[i] - run_sums[x];
          c = (span_cost[x][j-1] > seg) ? span_cost[x][j-1] : seg;
          if (c < best) begin
            best  = c;
            where = x;
          end
        end
        span_cost[i][j] = best;
        span_cut[i][j]  = where;
      end
    end
    // Walk the cuts back from the end of the list.
    ends[0] = 0;
    ends[k] = n;
    for (int j = k; j >= 2; j--) begin
      e = ends[j];
      ends[j-1] = (e <= 1) ? e : span_cut[e][j];
    end
    for (int j = 1; j <= k; j++) begin
      s = ends[j-1] + 1;
      e = ends[j];
      p.part_empty = (e < s);
      p.part_start = INDEX_W'(s);
      p.part_end   = INDEX_W'(p.part_empty ? s - 1 : e);
      p.part_sum   = PSUM_W'(p.part_empty ? 0 : run_sums[e] - run_sums[s-1]);
      p.last_part  = (j == k);
      parts_q.push_back(p);
    end
  endfunction

  always @(posedge clk_i) begin
    lpm_out_t want;
    if (cfg_we_i) num_parts_q <= cfg_wdata_i;
    if (in_valid_i && !in_stall_i) begin
      if (elem_count < NItems) begin
        elem_count++;
        run_sums[elem_count] = run_sums[elem_count-1] + in_data_i.element_value;
      end
      if (in_data_i.last_item) begin
        run_sums[0] = 0;
        plan_parts(elem_count, num_parts_q);
        elem_count = 0;
      end
    end
    if (out_valid_i && !out_stall_i) begin
      if (parts_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected part item %p", out_data_i);
      end else begin
        want = parts_q.pop_front();
        if (want !== out_data_i) begin
          fails++;
          if (fails <= 10) $display("part item: expected %p, got %p", want, out_data_i);
        end
      end
    end
  end

  initial run_sums[0] = 0;

endmodule

// ----- sim/tb_linear_partition_min_max_top.sv -----
module tb_linear_partition_min_max_top;
  import lpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 130;
  localparam int CycleLimit = 2_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [PARTS_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  lpm_in_t            in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  lpm_out_t           out_data_o;
  int                 pending;
  int                 fails;

  // Idle rates in percent for the sender and the receiver; they change as
  // the run moves through its three pressure phases.
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 items_sent = 0;
  int                 cycles = 0;

  linear_partition_min_max_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  lpm_partition_checker i_checker (
    .clk_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i  (in_stall_o),
    .in_data_i,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .out_data_i  (out_data_o),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The receiver stalls at random, changing only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // The run is bounded by a cycle count; the table fill for a full list with
  // sixteen parts is the slowest single step and fits many times over.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("linear_partition_min_max_top: mismatch");
      $finish;
    end
  end

  // Pick the pressure phase from how far the stimulus has come: first an
  // eager sender and a busy receiver, then the reverse, then full speed.
  function automatic void set_phase();
    if (items_sent < ItemTarget / 3) begin
      send_gap_pct   = 6;
      recv_stall_pct = 62;
    end else if (items_sent < 2 * ItemTarget / 3) begin
      send_gap_pct   = 62;
      recv_stall_pct = 6;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endfunction

  // Offers one element item and holds it until the block takes it. Valid is
  // left high so back-to-back items stream without a gap unless a random gap is drawn.
  task automatic send_elem(input logic [VALUE_W-1:0] value, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i              <= 1'b1;
    in_data_i.element_value <= value;
    in_data_i.last_item     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    set_phase();
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // The part count is only changed once the block has drained: every
  // expected part item has arrived and the backtrack pass is surely over.
  task automatic write_parts(input logic [PARTS_W-1:0] parts);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= parts;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Element values lean toward the extremes and toward small repeated values
  // so that ties between cuts show up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 3) return '1;
    if (r < 5) return '0;
    if (r < 9) return VALUE_W'($urandom_range(8));
    return VALUE_W'($urandom);
  endfunction

  task automatic send_list(input int len);
    for (int i = 1; i <= len; i++) send_elem(pick_value(), i == len);
    drop_valid();
  endtask

  initial begin
    int len;
    set_phase();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lists. A single maximum element with the reset part count of
    // three gives more parts than elements, so the trailing parts are empty.
    send_elem(16'hFFFF, 1'b1);
    drop_valid();
    // One part holds the whole list.
    write_parts(PARTS_W'(1));
    send_elem(16'h0000, 1'b0);
    send_elem(16'hFFFF, 1'b0);
    send_elem(16'h0007, 1'b1);
    drop_valid();
    // A part count of zero behaves as one.
    write_parts(PARTS_W'(0));
    send_elem(16'h5555, 1'b0);
    send_elem(16'hAAAA, 1'b1);
    drop_valid();
    // Counts above sixteen are clamped to sixteen.
    write_parts(PARTS_W'(31));
    send_elem(16'h0001, 1'b0);
    send_elem(16'h0002, 1'b0);
    send_elem(16'h0003, 1'b1);
    drop_valid();
    write_parts(PARTS_W'(16));
    for (int i = 0; i < 5; i++) send_elem(16'h8000 >> i, i == 4);
    drop_valid();
    // Equal elements make several cuts tie; the earliest one must win.
    write_parts(PARTS_W'(2));
    for (int i = 0; i < 4; i++) send_elem(16'h0004, i == 3);
    drop_valid();
    // Pause until every expected part item has come back.
    wait (pending == 0);

    // Random lists. One list overruns the capacity of sixty-four elements;
    // its tail is dropped but its last flag still starts the computation.
    write_parts(PARTS_W'(3));
    send_list(66);
    while (items_sent < ItemTarget) begin
      if ($urandom_range(2) == 0) begin
        write_parts(($urandom_range(3) == 0) ? PARTS_W'(16) : PARTS_W'($urandom));
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 8);
      send_list(len);
    end

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fails == 0) begin
      $display("linear_partition_min_max_top: match");
    end else begin
      $display("linear_partition_min_max_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lpm_pkg.sv
hdl/lpm_ram.sv
hdl/lpm_cmp_unit.sv
hdl/linear_partition_min_max_top.sv
sim/lpm_partition_checker.sv
sim/tb_linear_partition_min_max_top.sv
